// ===== design/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 hasher core.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef logic [31:0] word_t;

	// five chaining words, word 0 in the lowest slot
	typedef logic [4:0][31:0] chain_t;

	// commands from the sequencer to the compression unit
	typedef struct packed {
		logic start;
		logic init;
	} cmp_ctl_t;

	// status from the compression unit
	typedef struct packed {
		logic rounds;
		logic done;
	} cmp_sts_t;

	localparam int unsigned NUM_WORDS  = 5;
	localparam int unsigned NUM_ROUNDS = 80;
	localparam int unsigned RND_W      = 7;
	localparam int unsigned FILL_W     = 6;
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned BLOCK_BITS = 512;

	localparam logic [RND_W-1:0] RND_F2   = RND_W'(20);
	localparam logic [RND_W-1:0] RND_F3   = RND_W'(40);
	localparam logic [RND_W-1:0] RND_F4   = RND_W'(60);
	localparam logic [RND_W-1:0] RND_LAST = RND_W'(NUM_ROUNDS - 1);

	localparam word_t K1 = 32'h5A827999;
	localparam word_t K2 = 32'h6ED9EBA1;
	localparam word_t K3 = 32'h8F1BBCDC;
	localparam word_t K4 = 32'hCA62C1D6;

	localparam chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [FILL_W-1:0] FILL_LEN  = FILL_W'(56);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(63);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_WORDS - 1);

endpackage

// ===== design/sha1_msg_sched.sv =====
// ----------------------------------------------------------------------------
// sha1_msg_sched
// Block buffer and message schedule: bytes shift in one at a time, then the
// same 16-word window shifts one expanded word per round.
// ----------------------------------------------------------------------------
module sha1_msg_sched (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           byte_in,
	input  logic                 word_en,
	output sha1_pkg::word_t      w_word
);
	import sha1_pkg::*;

	logic [BLOCK_BITS-1:0] win_q;
	word_t                 w0, w2, w8, w13, w_mix, w_new;

	// taps of the schedule window, w0 is the oldest word
	assign w0    = win_q[BLOCK_BITS-1   -: 32];
	assign w2    = win_q[BLOCK_BITS-65  -: 32];
	assign w8    = win_q[BLOCK_BITS-257 -: 32];
	assign w13   = win_q[BLOCK_BITS-417 -: 32];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {w_mix[30:0], w_mix[31]};

	assign w_word = w0;

	// window shift, byte-wise while filling, word-wise while compressing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (word_en) begin
			win_q <= {win_q[BLOCK_BITS-33:0], w_new};
		end else if (byte_en) begin
			win_q <= {win_q[BLOCK_BITS-9:0], byte_in};
		end
	end

endmodule

// ===== design/sha1_compress.sv =====
// ----------------------------------------------------------------------------
// sha1_compress
// Compression unit: one shared round datapath stepped 80 times per block,
// then the working words fold into the chaining value.
// ----------------------------------------------------------------------------
module sha1_compress (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1_pkg::cmp_ctl_t   ctl,
	input  sha1_pkg::word_t      w_word,
	output sha1_pkg::cmp_sts_t   sts,
	output sha1_pkg::chain_t     chain
);
	import sha1_pkg::*;

	chain_t           cv_q;
	word_t            a_q, b_q, c_q, d_q, e_q;
	logic [RND_W-1:0] rnd_q;
	logic             busy_q, add_q;
	word_t            f, k, t;

	// round function and constant by round group
	always_comb begin
		if (rnd_q < RND_F2) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K1;
		end else if (rnd_q < RND_F3) begin
			f = b_q ^ c_q ^ d_q;
			k = K2;
		end else if (rnd_q < RND_F4) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K3;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K4;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_word;
	end

	// round sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			add_q  <= 1'b0;
			rnd_q  <= '0;
		end else begin
			add_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + RND_W'(1);
				if (rnd_q == RND_LAST) begin
					busy_q <= 1'b0;
					add_q  <= 1'b1;
				end
			end
		end
	end

	// working words
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
			e_q <= cv_q[4];
		end else if (busy_q) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// chaining value, back to the initial words for each new message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= IV;
		end else if (ctl.init) begin
			cv_q <= IV;
		end else if (add_q) begin
			cv_q[0] <= cv_q[0] + a_q;
			cv_q[1] <= cv_q[1] + b_q;
			cv_q[2] <= cv_q[2] + c_q;
			cv_q[3] <= cv_q[3] + d_q;
			cv_q[4] <= cv_q[4] + e_q;
		end
	end

	assign sts.rounds = busy_q;
	assign sts.done   = add_q;
	assign chain      = cv_q;

endmodule

// ===== design/sha1_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha1_message_hasher_core
// SHA-1 hasher: absorbs message bytes, pads on finish and emits the digest.
// ----------------------------------------------------------------------------
// absorb: a byte that completes a block waits in ST_ABS_WAIT for the rounds
// of the shared round unit and the chaining add
// finish: the pad byte, zero fill and length bytes go into the buffer, then each padded block
// (one or two) takes the rounds and the chaining add, then five words, one per accepted cycle
// throughput: one item at a time, s_tready is low while compressing, padding or emitting
// reset: chaining words return to the initial constants, counts clear
// ----------------------------------------------------------------------------
module sha1_message_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast    // last_word
);
	import sha1_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_ABS_WAIT = 8'b0000_0010,
		ST_PAD      = 8'b0000_0100,
		ST_PAD_WAIT = 8'b0000_1000,
		ST_LEN      = 8'b0001_0000,
		ST_LEN_WAIT = 8'b0010_0000,
		ST_EMIT     = 8'b0100_0000
	} state_t;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       bits_q;
	logic [IDX_W-1:0]  idx_q;

	cmp_ctl_t          cmp_ctl;
	cmp_sts_t          cmp_sts;
	chain_t            chain;
	word_t             w_word;
	logic              byte_en;
	logic [7:0]        byte_in;
	logic              in_acc, out_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign out_acc  = m_tvalid && m_tready;

	// byte into the block buffer: message, pad or length
	always_comb begin
		byte_en = 1'b0;
		byte_in = '0;
		case (state_q)
			ST_IDLE: begin
				byte_en = in_acc;
				byte_in = s_tuser ? PAD_BYTE : s_tdata;
			end
			ST_PAD: begin
				byte_en = (fill_q != FILL_LEN);
			end
			ST_LEN: begin
				byte_en = 1'b1;
				byte_in = bits_q[63:56];
			end
			default: begin
				byte_en = 1'b0;
			end
		endcase
	end

	// compression starts when the byte going in fills the block
	assign cmp_ctl.start = byte_en && (fill_q == FILL_LAST);
	assign cmp_ctl.init  = out_acc && (idx_q == IDX_LAST);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (byte_en) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser) begin
							state_q <= cmp_ctl.start ? ST_PAD_WAIT : ST_PAD;
						end else begin
							bits_q <= bits_q + 64'd8;
							if (cmp_ctl.start) begin
								state_q <= ST_ABS_WAIT;
							end
						end
					end
				end
				ST_ABS_WAIT: begin
					if (cmp_sts.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (fill_q == FILL_LEN) begin
						state_q <= ST_LEN;
					end else if (cmp_ctl.start) begin
						state_q <= ST_PAD_WAIT;
					end
				end
				ST_PAD_WAIT: begin
					if (cmp_sts.done) begin
						state_q <= ST_PAD;
					end
				end
				ST_LEN: begin
					// bit count shifts out msb first and ends at zero
					bits_q <= {bits_q[55:0], 8'h00};
					if (cmp_ctl.start) begin
						state_q <= ST_LEN_WAIT;
					end
				end
				ST_LEN_WAIT: begin
					if (cmp_sts.done) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (idx_q == IDX_LAST) begin
							state_q <= ST_IDLE;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digest word output from the chaining registers
	assign m_tdata = {5'b0_0000, idx_q, chain[idx_q]};
	assign m_tlast = (idx_q == IDX_LAST);

	sha1_msg_sched u_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.byte_in (byte_in),
		.word_en (cmp_sts.rounds),
		.w_word  (w_word)
	);

	sha1_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cmp_ctl),
		.w_word (w_word),
		.sts    (cmp_sts),
		.chain  (chain)
	);

endmodule
